>>> rtl/sdp_pkg.sv
// Shared types and constants for the SPH density / pressure block.
// Depends on nothing; used by sdp_mul and sph_density_pressure.
package sdp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Multiplier operand and product widths
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // Field widths
  localparam int WORD_W  = 32;
  localparam int WIDE_W  = 40;
  localparam int GROUP_W = 16;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = WIDE_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SMOOTH_LEN     = 3'd0,
    CFG_INV_SMOOTH_LEN = 3'd1,
    CFG_KERNEL_SCALE   = 3'd2,
    CFG_STIFFNESS      = 3'd3,
    CFG_DEFAULT_REST   = 3'd4,
    CFG_GROUP_MASK     = 3'd5
  } cfg_reg_t;

  // Register values after reset
  localparam logic [WORD_W-1:0]  RST_SMOOTH_LEN     = 32'd65536;
  localparam logic [WORD_W-1:0]  RST_INV_SMOOTH_LEN = 32'd65536;
  localparam logic [WORD_W-1:0]  RST_KERNEL_SCALE   = 32'd136902;
  localparam logic [WORD_W-1:0]  RST_STIFFNESS      = 32'd65536;
  localparam logic [WIDE_W-1:0]  RST_DEFAULT_REST   = 40'd65536000;
  localparam logic [GROUP_W-1:0] RST_GROUP_MASK     = 16'hFFFF;

  // Sequencer states: each *_MUL state issues a product, the following
  // state consumes it from the multiplier's product register.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_Q,
    ST_SQ_MUL,
    ST_SQ,
    ST_CUBE_MUL,
    ST_CUBE,
    ST_SHAPE_MUL,
    ST_SHAPE,
    ST_W_MUL,
    ST_W,
    ST_LO_MUL,
    ST_LO,
    ST_HI_MUL,
    ST_HI,
    ST_ACC,
    ST_FINAL
  } state_t;

  // What the saturating 32x40 product currently feeds
  typedef enum logic [1:0] {
    PH_NEIGHBOR,
    PH_SELF,
    PH_PRESS,
    PH_OUT
  } phase_t;

endpackage

>>> rtl/sdp_mul.sv
// Shared 32x32 unsigned multiplier with registered product and rounded view.
// Depends on sdp_pkg for operand and product widths.
module sdp_mul #(
  parameter int FRAC_BITS = sdp_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [sdp_pkg::MUL_W-1:0]   a,
  input  logic [sdp_pkg::MUL_W-1:0]   b,
  output logic [sdp_pkg::PROD_W-1:0]  prod,
  output logic [sdp_pkg::PROD_W-1:0]  prod_rnd
);

  localparam logic [sdp_pkg::PROD_W:0] HALF = (sdp_pkg::PROD_W+1)'(1) << (FRAC_BITS - 1);

  logic [sdp_pkg::PROD_W:0] rnd_sum;
  logic [sdp_pkg::PROD_W:0] rnd_shift;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // round half up, then drop the fraction
  always_comb begin
    rnd_sum   = {1'b0, prod} + HALF;
    rnd_shift = rnd_sum >> FRAC_BITS;
    prod_rnd  = rnd_shift[sdp_pkg::PROD_W-1:0];
  end

endmodule

>>> rtl/sph_density_pressure.sv
// Top level of the SPH density / pressure block (Lucy kernel, fixed point).
// Depends on sdp_pkg and the shared multiplier sdp_mul.
//
// Channel   Dir  Handshake             Payload
// item      in   item_valid/item_stall  one neighbor contact of the current particle
// result    out  result_valid/result_stall  density, pressure, rest density, skipped
// cfg       in   cfg_write             cfg_index selects the register, cfg_data the value
//
// A contact that contributes (valid, sphere, group hit, distance within h)
// makes seven passes through the single 32x32 multiplier, each an issue
// state and a consume state, plus the accumulate. A contact that adds nothing
// is taken in the idle state. The last item is followed by the self term (FINAL,
// LO/HI passes, ACC), another LO/HI pass for the pressure product when density
// exceeds rest, and the result load in ACC, which a skipped particle reaches from FINAL.
// Reset is synchronous and restores the registers to their defaults and
// clears the density sum. A new transaction is taken while a finished result
// still waits in the output register; the sequencer holds only when it must
// load a result and the register is full and stalled.
module sph_density_pressure #(
  parameter int FRAC_BITS = sdp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic                            last_neighbor,
  input  logic                            contact_valid,
  input  logic [sdp_pkg::WORD_W-1:0]      neighbor_mass,
  input  logic [sdp_pkg::WORD_W-1:0]      neighbor_distance,
  input  logic [sdp_pkg::GROUP_W-1:0]     neighbor_groups,
  input  logic [sdp_pkg::WORD_W-1:0]      own_mass,
  input  logic [sdp_pkg::GROUP_W-1:0]     own_groups,
  input  logic                            own_is_sphere,
  input  logic [sdp_pkg::WIDE_W-1:0]      own_rest_density,
  input  logic                            rest_density_unset,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [sdp_pkg::WIDE_W-1:0]      density,
  output logic [sdp_pkg::WIDE_W-1:0]      pressure,
  output logic [sdp_pkg::WIDE_W-1:0]      rest_density_used,
  output logic                            skipped,
  // configuration
  input  logic                            cfg_write,
  input  logic [sdp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sdp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int W32 = sdp_pkg::WORD_W;
  localparam int W40 = sdp_pkg::WIDE_W;
  localparam int MW  = sdp_pkg::MUL_W;
  localparam int PW  = sdp_pkg::PROD_W;
  // q and 1-q never exceed 1.0
  localparam int QW  = FRAC_BITS + 1;
  // combined width of the two partial products of a 32x40 multiply
  localparam int CW  = MW + W40 + 1;

  localparam logic [QW-1:0]   ONE_Q   = QW'(1) << FRAC_BITS;
  localparam logic [QW+1:0]   ONE_E   = (QW+2)'(1) << FRAC_BITS;
  localparam logic [PW-1:0]   ONE_P   = PW'(1) << FRAC_BITS;
  localparam logic [CW-1:0]   HALF_C  = CW'(1) << (FRAC_BITS - 1);
  localparam logic [W40-1:0]  MAX40   = {W40{1'b1}};

  function automatic logic [W40-1:0] sat_add40(input logic [W40-1:0] x,
                                               input logic [W40-1:0] y);
    logic [W40:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[W40] ? MAX40 : s[W40-1:0];
  endfunction

  // configuration registers
  logic [W32-1:0]              smooth_len;
  logic [W32-1:0]              inv_smooth_len;
  logic [W32-1:0]              kernel_scale;
  logic [W32-1:0]              stiffness;
  logic [W40-1:0]              default_rest;
  logic [sdp_pkg::GROUP_W-1:0] group_mask;

  // sequencer
  sdp_pkg::state_t state, state_next;
  sdp_pkg::phase_t phase;

  // datapath
  logic [W40-1:0]              sum;
  logic                        last_r;
  logic [W32-1:0]              own_mass_r;
  logic [sdp_pkg::GROUP_W-1:0] own_groups_r;
  logic [W40-1:0]              rest_r;
  logic [QW-1:0]               q_r;
  logic [QW-1:0]               om_r;
  logic [W32-1:0]              tmp_r;
  logic [W32-1:0]              mula_r;
  logic [W40-1:0]              wk_r;
  logic [PW-1:0]               lo_r;
  logic [W40-1:0]              prod_r;
  logic [W40-1:0]              rho_r;
  logic [W40-1:0]              press_r;
  logic                        skip_r;

  // multiplier
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod, prod_rnd;

  // combinational helpers
  logic           item_hits;
  logic           part_skip;
  logic           out_load;
  logic [QW-1:0]  q_clamp;
  logic [QW+1:0]  one_p3q;
  logic [CW-1:0]  comb_sum;
  logic [CW-1:0]  comb_shift;
  logic [W40-1:0] comb_sat;
  logic [W40-1:0] rho_sum;
  logic           rho_gt;

  sdp_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk      (clk),
    .a        (mul_a),
    .b        (mul_b),
    .prod     (prod),
    .prod_rnd (prod_rnd)
  );

  always_comb begin
    // a contact inside the support of an accepted neighbor
    item_hits = contact_valid && own_is_sphere && ((neighbor_groups & group_mask) != '0)
                && (neighbor_distance <= smooth_len);
    part_skip = (group_mask != '0) && ((own_groups_r & group_mask) == '0);
    q_clamp   = (prod_rnd > ONE_P) ? ONE_Q : prod_rnd[QW-1:0];
    one_p3q   = ONE_E + {1'b0, q_r, 1'b0} + {2'b00, q_r};
    // low partial + high partial shifted up, rounded, saturated to 40 bits
    comb_sum   = {1'b0, prod[W40-1:0], {MW{1'b0}}} + {{(CW-PW){1'b0}}, lo_r} + HALF_C;
    comb_shift = comb_sum >> FRAC_BITS;
    comb_sat   = (comb_shift[CW-1:W40] != '0) ? MAX40 : comb_shift[W40-1:0];
    rho_sum    = sat_add40(sum, prod_r);
    rho_gt     = rho_sum > rest_r;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sdp_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item_hits) begin
            state_next = sdp_pkg::ST_Q;
          end else if (last_neighbor) begin
            state_next = sdp_pkg::ST_FINAL;
          end
        end
      end
      sdp_pkg::ST_Q:         state_next = sdp_pkg::ST_SQ_MUL;
      sdp_pkg::ST_SQ_MUL:    state_next = sdp_pkg::ST_SQ;
      sdp_pkg::ST_SQ:        state_next = sdp_pkg::ST_CUBE_MUL;
      sdp_pkg::ST_CUBE_MUL:  state_next = sdp_pkg::ST_CUBE;
      sdp_pkg::ST_CUBE:      state_next = sdp_pkg::ST_SHAPE_MUL;
      sdp_pkg::ST_SHAPE_MUL: state_next = sdp_pkg::ST_SHAPE;
      sdp_pkg::ST_SHAPE:     state_next = sdp_pkg::ST_W_MUL;
      sdp_pkg::ST_W_MUL:     state_next = sdp_pkg::ST_W;
      sdp_pkg::ST_W:         state_next = sdp_pkg::ST_LO_MUL;
      sdp_pkg::ST_LO_MUL:    state_next = sdp_pkg::ST_LO;
      sdp_pkg::ST_LO:        state_next = sdp_pkg::ST_HI_MUL;
      sdp_pkg::ST_HI_MUL:    state_next = sdp_pkg::ST_HI;
      sdp_pkg::ST_HI:        state_next = sdp_pkg::ST_ACC;
      sdp_pkg::ST_ACC: begin
        case (phase)
          sdp_pkg::PH_NEIGHBOR: state_next = last_r ? sdp_pkg::ST_FINAL : sdp_pkg::ST_IDLE;
          sdp_pkg::PH_SELF: begin
            state_next = rho_gt ? sdp_pkg::ST_LO_MUL : sdp_pkg::ST_ACC;
          end
          sdp_pkg::PH_PRESS: state_next = sdp_pkg::ST_ACC;
          sdp_pkg::PH_OUT:   state_next = out_load ? sdp_pkg::ST_IDLE : sdp_pkg::ST_ACC;
          default:           state_next = sdp_pkg::ST_IDLE;
        endcase
      end
      sdp_pkg::ST_FINAL: state_next = part_skip ? sdp_pkg::ST_ACC : sdp_pkg::ST_LO_MUL;
      default:           state_next = sdp_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operand selection
  always_comb begin
    item_stall = (state != sdp_pkg::ST_IDLE);
    out_load   = (state == sdp_pkg::ST_ACC) && (phase == sdp_pkg::PH_OUT)
                 && (!result_valid || !result_stall);
    mul_a = '0;
    mul_b = '0;
    case (state)
      sdp_pkg::ST_IDLE: begin
        mul_a = neighbor_distance;
        mul_b = inv_smooth_len;
      end
      sdp_pkg::ST_SQ_MUL: begin
        mul_a = {{(MW-QW){1'b0}}, om_r};
        mul_b = {{(MW-QW){1'b0}}, om_r};
      end
      sdp_pkg::ST_CUBE_MUL: begin
        mul_a = tmp_r;
        mul_b = {{(MW-QW){1'b0}}, om_r};
      end
      sdp_pkg::ST_SHAPE_MUL: begin
        mul_a = {{(MW-QW-2){1'b0}}, one_p3q};
        mul_b = tmp_r;
      end
      sdp_pkg::ST_W_MUL: begin
        mul_a = kernel_scale;
        mul_b = tmp_r;
      end
      sdp_pkg::ST_LO_MUL: begin
        mul_a = mula_r;
        mul_b = wk_r[MW-1:0];
      end
      sdp_pkg::ST_HI_MUL: begin
        mul_a = mula_r;
        mul_b = {{(MW-(W40-MW)){1'b0}}, wk_r[W40-1:MW]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // control state, configuration and density sum
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= sdp_pkg::ST_IDLE;
      phase          <= sdp_pkg::PH_NEIGHBOR;
      sum            <= '0;
      result_valid   <= 1'b0;
      smooth_len     <= sdp_pkg::RST_SMOOTH_LEN;
      inv_smooth_len <= sdp_pkg::RST_INV_SMOOTH_LEN;
      kernel_scale   <= sdp_pkg::RST_KERNEL_SCALE;
      stiffness      <= sdp_pkg::RST_STIFFNESS;
      default_rest   <= sdp_pkg::RST_DEFAULT_REST;
      group_mask     <= sdp_pkg::RST_GROUP_MASK;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          sdp_pkg::CFG_SMOOTH_LEN:     smooth_len     <= cfg_data[W32-1:0];
          sdp_pkg::CFG_INV_SMOOTH_LEN: inv_smooth_len <= cfg_data[W32-1:0];
          sdp_pkg::CFG_KERNEL_SCALE:   kernel_scale   <= cfg_data[W32-1:0];
          sdp_pkg::CFG_STIFFNESS:      stiffness      <= cfg_data[W32-1:0];
          sdp_pkg::CFG_DEFAULT_REST:   default_rest   <= cfg_data[W40-1:0];
          sdp_pkg::CFG_GROUP_MASK:     group_mask     <= cfg_data[sdp_pkg::GROUP_W-1:0];
          default: ;
        endcase
      end

      // hold the result while stalled, drop it once taken
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        sdp_pkg::ST_IDLE: begin
          if (item_valid) begin
            phase <= sdp_pkg::PH_NEIGHBOR;
          end
        end
        sdp_pkg::ST_ACC: begin
          case (phase)
            sdp_pkg::PH_NEIGHBOR: sum <= sat_add40(sum, prod_r);
            sdp_pkg::PH_SELF: begin
              sum   <= '0;
              phase <= rho_gt ? sdp_pkg::PH_PRESS : sdp_pkg::PH_OUT;
            end
            sdp_pkg::PH_PRESS: phase <= sdp_pkg::PH_OUT;
            default: ;
          endcase
        end
        sdp_pkg::ST_FINAL: begin
          if (part_skip) begin
            sum   <= '0;
            phase <= sdp_pkg::PH_OUT;
          end else begin
            phase <= sdp_pkg::PH_SELF;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      sdp_pkg::ST_IDLE: begin
        if (item_valid) begin
          last_r       <= last_neighbor;
          mula_r       <= neighbor_mass;
          own_mass_r   <= own_mass;
          own_groups_r <= own_groups;
          rest_r       <= rest_density_unset ? default_rest : own_rest_density;
        end
      end
      sdp_pkg::ST_Q: begin
        q_r  <= q_clamp;
        om_r <= ONE_Q - q_clamp;
      end
      sdp_pkg::ST_SQ,
      sdp_pkg::ST_CUBE,
      sdp_pkg::ST_SHAPE: tmp_r <= prod_rnd[W32-1:0];
      sdp_pkg::ST_W:     wk_r  <= prod_rnd[W40-1:0];
      sdp_pkg::ST_LO:    lo_r  <= prod;
      sdp_pkg::ST_HI:    prod_r <= comb_sat;
      sdp_pkg::ST_ACC: begin
        case (phase)
          sdp_pkg::PH_SELF: begin
            rho_r  <= rho_sum;
            skip_r <= 1'b0;
            if (rho_gt) begin
              mula_r <= stiffness;
              wk_r   <= rho_sum - rest_r;
            end else begin
              press_r <= '0;
            end
          end
          sdp_pkg::PH_PRESS: press_r <= prod_r;
          default: ;
        endcase
      end
      sdp_pkg::ST_FINAL: begin
        if (part_skip) begin
          rho_r   <= '0;
          press_r <= '0;
          skip_r  <= 1'b1;
        end else begin
          // self term: W(0) equals the kernel scale exactly
          mula_r <= own_mass_r;
          wk_r   <= {{(W40-W32){1'b0}}, kernel_scale};
        end
      end
      default: ;
    endcase

    if (out_load) begin
      density           <= rho_r;
      pressure          <= press_r;
      rest_density_used <= skip_r ? '0 : rest_r;
      skipped           <= skip_r;
    end
  end

  // a loaded result sends the sequencer back for the next transaction
  a_load_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == sdp_pkg::ST_IDLE))
    else $error("sequencer did not return to idle after loading a result");

  // the density sum is clear whenever a result is about to be loaded
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (sum == '0))
    else $error("density sum not cleared at end of particle");

  // a skipped particle reports all-zero fields
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && skipped) |->
      ((density == '0) && (pressure == '0) && (rest_density_used == '0)))
    else $error("skipped result carries nonzero fields");

  // pressure only when density exceeds rest density
  a_press_pos: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !skipped && (pressure != '0)) |-> (density > rest_density_used))
    else $error("pressure reported with density at or below rest");

endmodule
